### rtl/ecsm_pkg.sv
`timescale 1ns / 1ps
// shared constants, codes and types for the ec point scalar multiplier
// no dependencies
package ecsm_pkg;

    localparam int FIELD_BITS  = 31;
    localparam int SCALAR_BITS = 32;
    localparam int CNT_W       = $clog2(SCALAR_BITS + 1);
    localparam int ALU_CNT_W   = $clog2(FIELD_BITS);
    localparam int CFG_IDX_W   = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CURVE_A = 1'd1;

    // reset values of the configuration registers and the smallest working modulus
    localparam logic [FIELD_BITS-1:0] MODULUS_RST = FIELD_BITS'(97);
    localparam logic [FIELD_BITS-1:0] CURVE_A_RST = FIELD_BITS'(2);
    localparam logic [FIELD_BITS-1:0] MIN_MODULUS = FIELD_BITS'(3);

    // shared unit operation codes
    localparam logic [1:0] OP_MUL = 2'd0;
    localparam logic [1:0] OP_DIV = 2'd1;
    localparam logic [1:0] OP_ADD = 2'd2;
    localparam logic [1:0] OP_SUB = 2'd3;

    typedef struct packed {
        logic                  start;
        logic [1:0]            op;
        logic [FIELD_BITS-1:0] a;
        logic [FIELD_BITS-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic                  done;
        logic [FIELD_BITS-1:0] res;
        logic [FIELD_BITS-1:0] quo;
    } alu_rsp_t;

endpackage

### rtl/ecsm_if.sv
`timescale 1ns / 1ps
// valid/ready channels for base point beats and result beats
// depends on ecsm_pkg
interface ecsm_in_if;
    logic                            valid;
    logic                            ready;
    logic [ecsm_pkg::FIELD_BITS-1:0]  point_x;
    logic [ecsm_pkg::FIELD_BITS-1:0]  point_y;
    logic [ecsm_pkg::SCALAR_BITS-1:0] scalar;

    modport source (output valid, point_x, point_y, scalar, input ready);
    modport sink   (input valid, point_x, point_y, scalar, output ready);
endinterface

interface ecsm_out_if;
    logic                           valid;
    logic                           ready;
    logic [ecsm_pkg::FIELD_BITS-1:0] result_x;
    logic [ecsm_pkg::FIELD_BITS-1:0] result_y;
    logic                           at_infinity;

    modport source (output valid, result_x, result_y, at_infinity, input ready);
    modport sink   (input valid, result_x, result_y, at_infinity, output ready);
endinterface

### rtl/ecsm_alu.sv
`timescale 1ns / 1ps
// shared modular unit: bit-serial multiply mod p, restoring divide, add/sub mod p
// depends on ecsm_pkg
module ecsm_alu
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  ecsm_pkg::alu_req_t              req,
    input  logic [ecsm_pkg::FIELD_BITS-1:0] p,
    output ecsm_pkg::alu_rsp_t              rsp
);

    localparam int FB = ecsm_pkg::FIELD_BITS;

    logic                         busy_reg;
    logic                         done_reg;
    logic [1:0]                   op_reg;
    logic [FB-1:0]                a_reg;
    logic [FB-1:0]                b_reg;
    logic [FB:0]                  acc_reg;
    logic [FB-1:0]                quo_reg;
    logic [ecsm_pkg::ALU_CNT_W-1:0] cnt_reg;

    logic [FB:0] dbl, dbl_red, sum, sum_red, mul_next;
    logic [FB:0] shf, div_next;
    logic        div_ge;
    logic [FB:0] add_raw, add_res, sub_res;

    // multiply step: double, reduce, conditionally add, reduce
    always_comb
    begin
        dbl      = {acc_reg[FB-1:0], 1'b0};
        dbl_red  = (dbl >= {1'b0, p}) ? dbl - {1'b0, p} : dbl;
        sum      = dbl_red + {1'b0, a_reg};
        sum_red  = (sum >= {1'b0, p}) ? sum - {1'b0, p} : sum;
        mul_next = b_reg[FB-1] ? sum_red : dbl_red;
    end

    // divide step: shift in next dividend bit, trial subtract
    always_comb
    begin
        shf      = {acc_reg[FB-1:0], a_reg[FB-1]};
        div_ge   = (shf >= {1'b0, b_reg});
        div_next = div_ge ? shf - {1'b0, b_reg} : shf;
    end

    // add and subtract mod p, combinational on the request operands
    always_comb
    begin
        add_raw = {1'b0, req.a} + {1'b0, req.b};
        add_res = (add_raw >= {1'b0, p}) ? add_raw - {1'b0, p} : add_raw;
        sub_res = (req.a >= req.b) ? {1'b0, req.a} - {1'b0, req.b}
                                   : {1'b0, req.a} + {1'b0, p} - {1'b0, req.b};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                if (req.op == ecsm_pkg::OP_ADD || req.op == ecsm_pkg::OP_SUB)
                    done_reg <= 1'b1;
                else
                    busy_reg <= 1'b1;
            end
            else if (busy_reg && cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            op_reg  <= req.op;
            a_reg   <= req.a;
            b_reg   <= req.b;
            cnt_reg <= ecsm_pkg::ALU_CNT_W'(FB - 1);
            quo_reg <= '0;
            case (req.op)
                ecsm_pkg::OP_ADD: acc_reg <= add_res;
                ecsm_pkg::OP_SUB: acc_reg <= sub_res;
                default:          acc_reg <= '0;
            endcase
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            case (op_reg)
                ecsm_pkg::OP_MUL:
                begin
                    acc_reg <= mul_next;
                    b_reg   <= {b_reg[FB-2:0], 1'b0};
                end
                ecsm_pkg::OP_DIV:
                begin
                    acc_reg <= div_next;
                    a_reg   <= {a_reg[FB-2:0], 1'b0};
                    quo_reg <= {quo_reg[FB-2:0], div_ge};
                end
                default:
                begin
                    acc_reg <= acc_reg;
                end
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.res  = acc_reg[FB-1:0];
    assign rsp.quo  = quo_reg;

endmodule

### rtl/ec_point_scalar_multiply.sv
`timescale 1ns / 1ps
// top level: sequencer for affine double-and-add over the shared modular unit
// depends on ecsm_pkg, ecsm_if, ecsm_alu
//
// usage
// pt_in carries one beat per job: base point (point_x, point_y) and scalar.
// pt_out returns one beat per job: result_x, result_y and at_infinity
// (coordinates read zero when the result is the point at infinity).
// modulus and curve_a are written through cfg_we / cfg_index / cfg_data
// while the block is idle; reset loads modulus 97 and curve_a 2.
// pt_in.ready is high only in the idle state; one job runs at a time.
// every field operation goes through one shared unit: a multiply or a
// divide runs bit-serially, an add or subtract is formed combinationally.
// each inversion runs one Euclid round (check, divide, multiply, subtract)
// per quotient step, at most ~45 rounds for 31-bit values.
// a job of SCALAR_BITS bits takes up to two point operations per bit,
// and the number of inversion rounds dominates the length of a job.
// a finished result sits in the output register; if pt_out stalls the
// block holds the next result in its final state until the register frees,
// and the block returns to idle after handing it over.
// reset clears the sequencer and the output valid flag at once.
module ec_point_scalar_multiply
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    ecsm_in_if.sink                              pt_in,
    ecsm_out_if.source                           pt_out,
    input  logic                                 cfg_we,
    input  logic [ecsm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ecsm_pkg::FIELD_BITS-1:0]      cfg_data
);

    localparam int FB = ecsm_pkg::FIELD_BITS;
    localparam int SB = ecsm_pkg::SCALAR_BITS;
    localparam int CW = ecsm_pkg::CNT_W;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_RX    = 5'd1;
    localparam logic [4:0] S_RY    = 5'd2;
    localparam logic [4:0] S_RA    = 5'd3;
    localparam logic [4:0] S_LOOP  = 5'd4;
    localparam logic [4:0] S_DCHK  = 5'd5;
    localparam logic [4:0] S_D_SQ  = 5'd6;
    localparam logic [4:0] S_D_3A  = 5'd7;
    localparam logic [4:0] S_D_3B  = 5'd8;
    localparam logic [4:0] S_D_A   = 5'd9;
    localparam logic [4:0] S_D_2Y  = 5'd10;
    localparam logic [4:0] S_A_NUM = 5'd11;
    localparam logic [4:0] S_A_DEN = 5'd12;
    localparam logic [4:0] S_I_CHK = 5'd13;
    localparam logic [4:0] S_I_DIV = 5'd14;
    localparam logic [4:0] S_I_MUL = 5'd15;
    localparam logic [4:0] S_I_SUB = 5'd16;
    localparam logic [4:0] S_SLOPE = 5'd17;
    localparam logic [4:0] S_F_SS  = 5'd18;
    localparam logic [4:0] S_F_X1  = 5'd19;
    localparam logic [4:0] S_F_X2  = 5'd20;
    localparam logic [4:0] S_F_D   = 5'd21;
    localparam logic [4:0] S_F_M   = 5'd22;
    localparam logic [4:0] S_F_Y   = 5'd23;
    localparam logic [4:0] S_DONE  = 5'd24;

    logic [4:0]    state_reg;
    logic          pend_reg;
    logic [FB-1:0] modulus_reg, curve_a_reg;
    logic [FB-1:0] p_reg, ca_reg;
    logic [FB-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic          ainf_reg, binf_reg;
    logic [SB-1:0] k_reg;
    logic [CW-1:0] i_reg;
    logic [FB-1:0] x1_reg, y1_reg, x2_reg;
    logic [FB-1:0] num_reg, s_reg, rx_reg, tmp_reg;
    logic [FB-1:0] r0_reg, r1_reg, t0_reg, t1_reg, q_reg;
    logic          dst_acc_reg;
    logic          out_valid_reg, out_inf_reg;
    logic [FB-1:0] out_x_reg, out_y_reg;

    ecsm_pkg::alu_req_t alu_req;
    ecsm_pkg::alu_rsp_t alu_rsp;
    logic               op_state;
    logic [FB-1:0]      q_red;
    logic [FB-1:0]      p_eff;
    logic               out_load;

    assign q_red = (q_reg == p_reg) ? '0 : q_reg;
    assign p_eff = (modulus_reg < ecsm_pkg::MIN_MODULUS) ? ecsm_pkg::MIN_MODULUS
                                                         : modulus_reg;
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || pt_out.ready);

    // operation issued by each sequencer step
    always_comb
    begin
        op_state  = 1'b1;
        alu_req.op = ecsm_pkg::OP_ADD;
        alu_req.a  = '0;
        alu_req.b  = '0;
        case (state_reg)
            S_RX:    begin alu_req.op = ecsm_pkg::OP_DIV; alu_req.a = bx_reg;  alu_req.b = p_reg;  end
            S_RY:    begin alu_req.op = ecsm_pkg::OP_DIV; alu_req.a = by_reg;  alu_req.b = p_reg;  end
            S_RA:    begin alu_req.op = ecsm_pkg::OP_DIV; alu_req.a = ca_reg;  alu_req.b = p_reg;  end
            S_D_SQ:  begin alu_req.op = ecsm_pkg::OP_MUL; alu_req.a = x1_reg;  alu_req.b = x1_reg; end
            S_D_3A:  begin alu_req.op = ecsm_pkg::OP_ADD; alu_req.a = tmp_reg; alu_req.b = tmp_reg; end
            S_D_3B:  begin alu_req.op = ecsm_pkg::OP_ADD; alu_req.a = num_reg; alu_req.b = tmp_reg; end
            S_D_A:   begin alu_req.op = ecsm_pkg::OP_ADD; alu_req.a = num_reg; alu_req.b = ca_reg; end
            S_D_2Y:  begin alu_req.op = ecsm_pkg::OP_ADD; alu_req.a = y1_reg;  alu_req.b = y1_reg; end
            S_A_NUM: begin alu_req.op = ecsm_pkg::OP_SUB; alu_req.a = y1_reg;  alu_req.b = by_reg; end
            S_A_DEN: begin alu_req.op = ecsm_pkg::OP_SUB; alu_req.a = x1_reg;  alu_req.b = x2_reg; end
            S_I_DIV: begin alu_req.op = ecsm_pkg::OP_DIV; alu_req.a = r0_reg;  alu_req.b = r1_reg; end
            S_I_MUL: begin alu_req.op = ecsm_pkg::OP_MUL; alu_req.a = q_red;   alu_req.b = t1_reg; end
            S_I_SUB: begin alu_req.op = ecsm_pkg::OP_SUB; alu_req.a = t0_reg;  alu_req.b = tmp_reg; end
            S_SLOPE: begin alu_req.op = ecsm_pkg::OP_MUL; alu_req.a = num_reg; alu_req.b = t0_reg; end
            S_F_SS:  begin alu_req.op = ecsm_pkg::OP_MUL; alu_req.a = s_reg;   alu_req.b = s_reg;  end
            S_F_X1:  begin alu_req.op = ecsm_pkg::OP_SUB; alu_req.a = tmp_reg; alu_req.b = x1_reg; end
            S_F_X2:  begin alu_req.op = ecsm_pkg::OP_SUB; alu_req.a = rx_reg;  alu_req.b = x2_reg; end
            S_F_D:   begin alu_req.op = ecsm_pkg::OP_SUB; alu_req.a = x1_reg;  alu_req.b = rx_reg; end
            S_F_M:   begin alu_req.op = ecsm_pkg::OP_MUL; alu_req.a = s_reg;   alu_req.b = tmp_reg; end
            S_F_Y:   begin alu_req.op = ecsm_pkg::OP_SUB; alu_req.a = tmp_reg; alu_req.b = y1_reg; end
            default: op_state = 1'b0;
        endcase
        alu_req.start = op_state && !pend_reg;
    end

    ecsm_alu u_alu
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .p     (p_reg),
        .rsp   (alu_rsp)
    );

    assign pt_in.ready        = (state_reg == S_IDLE);
    assign pt_out.valid       = out_valid_reg;
    assign pt_out.result_x    = out_x_reg;
    assign pt_out.result_y    = out_y_reg;
    assign pt_out.at_infinity = out_inf_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= ecsm_pkg::MODULUS_RST;
            curve_a_reg <= ecsm_pkg::CURVE_A_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ecsm_pkg::REG_MODULUS: modulus_reg <= cfg_data;
                ecsm_pkg::REG_CURVE_A: curve_a_reg <= cfg_data;
                default:               modulus_reg <= modulus_reg;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (pt_out.valid && pt_out.ready)
                out_valid_reg <= 1'b0;
            if (alu_rsp.done)
                pend_reg <= 1'b0;
            else if (alu_req.start)
                pend_reg <= 1'b1;

            case (state_reg)
                S_IDLE:
                begin
                    if (pt_in.valid)
                    begin
                        bx_reg    <= pt_in.point_x;
                        by_reg    <= pt_in.point_y;
                        k_reg     <= pt_in.scalar;
                        ca_reg    <= curve_a_reg;
                        p_reg     <= p_eff;
                        state_reg <= S_RX;
                    end
                end
                S_RX: if (alu_rsp.done) begin bx_reg <= alu_rsp.res; state_reg <= S_RY; end
                S_RY: if (alu_rsp.done) begin by_reg <= alu_rsp.res; state_reg <= S_RA; end
                S_RA:
                begin
                    if (alu_rsp.done)
                    begin
                        ca_reg    <= alu_rsp.res;
                        ainf_reg  <= 1'b1;
                        binf_reg  <= 1'b0;
                        i_reg     <= '0;
                        state_reg <= S_LOOP;
                    end
                end
                // end check and add step for the current scalar bit
                S_LOOP:
                begin
                    if (i_reg == CW'(SB))
                        state_reg <= S_DONE;
                    else if (!k_reg[0])
                        state_reg <= S_DCHK;
                    else if (ainf_reg)
                    begin
                        ax_reg    <= bx_reg;
                        ay_reg    <= by_reg;
                        ainf_reg  <= binf_reg;
                        state_reg <= S_DCHK;
                    end
                    else if (binf_reg)
                        state_reg <= S_DCHK;
                    else if (ax_reg == bx_reg)
                    begin
                        if (ay_reg == by_reg && ay_reg != '0)
                        begin
                            x1_reg      <= ax_reg;
                            y1_reg      <= ay_reg;
                            x2_reg      <= ax_reg;
                            dst_acc_reg <= 1'b1;
                            state_reg   <= S_D_SQ;
                        end
                        else
                        begin
                            ainf_reg  <= 1'b1;
                            state_reg <= S_DCHK;
                        end
                    end
                    else
                    begin
                        x1_reg      <= ax_reg;
                        y1_reg      <= ay_reg;
                        x2_reg      <= bx_reg;
                        dst_acc_reg <= 1'b1;
                        state_reg   <= S_A_NUM;
                    end
                end
                // doubling step of the running base point
                S_DCHK:
                begin
                    if (binf_reg || by_reg == '0)
                    begin
                        binf_reg  <= 1'b1;
                        i_reg     <= i_reg + 1'b1;
                        k_reg     <= k_reg >> 1;
                        state_reg <= S_LOOP;
                    end
                    else
                    begin
                        x1_reg      <= bx_reg;
                        y1_reg      <= by_reg;
                        x2_reg      <= bx_reg;
                        dst_acc_reg <= 1'b0;
                        state_reg   <= S_D_SQ;
                    end
                end
                S_D_SQ: if (alu_rsp.done) begin tmp_reg <= alu_rsp.res; state_reg <= S_D_3A; end
                S_D_3A: if (alu_rsp.done) begin num_reg <= alu_rsp.res; state_reg <= S_D_3B; end
                S_D_3B: if (alu_rsp.done) begin num_reg <= alu_rsp.res; state_reg <= S_D_A;  end
                S_D_A:  if (alu_rsp.done) begin num_reg <= alu_rsp.res; state_reg <= S_D_2Y; end
                S_A_NUM: if (alu_rsp.done) begin num_reg <= alu_rsp.res; state_reg <= S_A_DEN; end
                S_D_2Y, S_A_DEN:
                begin
                    if (alu_rsp.done)
                    begin
                        r1_reg    <= alu_rsp.res;
                        r0_reg    <= p_reg;
                        t0_reg    <= '0;
                        t1_reg    <= FB'(1);
                        state_reg <= S_I_CHK;
                    end
                end
                // extended euclid rounds
                S_I_CHK: state_reg <= (r1_reg == '0) ? S_SLOPE : S_I_DIV;
                S_I_DIV:
                begin
                    if (alu_rsp.done)
                    begin
                        r0_reg    <= r1_reg;
                        r1_reg    <= alu_rsp.res;
                        q_reg     <= alu_rsp.quo;
                        state_reg <= S_I_MUL;
                    end
                end
                S_I_MUL: if (alu_rsp.done) begin tmp_reg <= alu_rsp.res; state_reg <= S_I_SUB; end
                S_I_SUB:
                begin
                    if (alu_rsp.done)
                    begin
                        t0_reg    <= t1_reg;
                        t1_reg    <= alu_rsp.res;
                        state_reg <= S_I_CHK;
                    end
                end
                // slope and new coordinates
                S_SLOPE: if (alu_rsp.done) begin s_reg   <= alu_rsp.res; state_reg <= S_F_SS; end
                S_F_SS:  if (alu_rsp.done) begin tmp_reg <= alu_rsp.res; state_reg <= S_F_X1; end
                S_F_X1:  if (alu_rsp.done) begin rx_reg  <= alu_rsp.res; state_reg <= S_F_X2; end
                S_F_X2:  if (alu_rsp.done) begin rx_reg  <= alu_rsp.res; state_reg <= S_F_D;  end
                S_F_D:   if (alu_rsp.done) begin tmp_reg <= alu_rsp.res; state_reg <= S_F_M;  end
                S_F_M:   if (alu_rsp.done) begin tmp_reg <= alu_rsp.res; state_reg <= S_F_Y;  end
                S_F_Y:
                begin
                    if (alu_rsp.done)
                    begin
                        if (dst_acc_reg)
                        begin
                            ax_reg    <= rx_reg;
                            ay_reg    <= alu_rsp.res;
                            ainf_reg  <= 1'b0;
                            state_reg <= S_DCHK;
                        end
                        else
                        begin
                            bx_reg    <= rx_reg;
                            by_reg    <= alu_rsp.res;
                            binf_reg  <= 1'b0;
                            i_reg     <= i_reg + 1'b1;
                            k_reg     <= k_reg >> 1;
                            state_reg <= S_LOOP;
                        end
                    end
                end
                // hand the result to the output register
                S_DONE:
                begin
                    if (out_load)
                    begin
                        out_inf_reg   <= ainf_reg;
                        out_x_reg     <= ainf_reg ? '0 : ax_reg;
                        out_y_reg     <= ainf_reg ? '0 : ay_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // infinity beats carry zero coordinates
    assert property (@(posedge clk) disable iff (!rst_n)
        pt_out.valid && pt_out.at_infinity |-> pt_out.result_x == '0 && pt_out.result_y == '0)
        else $error("infinity result with nonzero coordinates");

    // finite results are reduced below the working modulus
    assert property (@(posedge clk) disable iff (!rst_n)
        pt_out.valid && !pt_out.at_infinity |-> pt_out.result_x < p_reg && pt_out.result_y < p_reg)
        else $error("result coordinate not reduced");

    // an accepted beat closes the input until the job ends
    assert property (@(posedge clk) disable iff (!rst_n)
        pt_in.valid && pt_in.ready |=> !pt_in.ready)
        else $error("input accepted twice");

    // shared unit answers only an outstanding request
    assert property (@(posedge clk) disable iff (!rst_n)
        alu_rsp.done |-> pend_reg)
        else $error("unit done without a request");

    // working modulus is never below three during a job
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> p_reg >= ecsm_pkg::MIN_MODULUS)
        else $error("working modulus below three");

endmodule

### verif/ec_point_scalar_multiply_test.sv
`timescale 1ns / 1ps
// self-checking bench for the affine double-and-add point multiplier
// depends on ecsm_pkg, ecsm_in_if, ecsm_out_if and ec_point_scalar_multiply
module ec_point_scalar_multiply_test;

    localparam int IDLE_LIMIT = 2000000;
    localparam int RX_HOLD    = 150000;
    localparam int SETTLE     = 50;

    typedef struct {
        longint unsigned x;
        longint unsigned y;
        bit              inf;
    } affine_pt_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [ecsm_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [ecsm_pkg::FIELD_BITS-1:0] cfg_data;

    ecsm_in_if  in_ch ();
    ecsm_out_if out_ch ();

    ec_point_scalar_multiply u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pt_in     (in_ch.sink),
        .pt_out    (out_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow copies of the configuration registers
    logic [ecsm_pkg::FIELD_BITS-1:0] modulus_q;
    logic [ecsm_pkg::FIELD_BITS-1:0] curve_a_q;

    affine_pt_t expected_pts[$];
    int  mismatches  = 0;
    int  idle_cycles = 0;
    int  rx_hold_cnt = 0;
    int  hold_req    = 0;
    int  hold_seen   = 0;
    bit  calm;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // field arithmetic on 64-bit integers
    function automatic longint unsigned fmul(longint unsigned u, longint unsigned v,
                                             longint unsigned p);
        return (u % p) * (v % p) % p;
    endfunction

    function automatic longint unsigned fsub(longint unsigned u, longint unsigned v,
                                             longint unsigned p);
        return (u % p + p - v % p) % p;
    endfunction

    // extended euclid coefficient, also defined for composite moduli
    function automatic longint unsigned finv(longint unsigned v, longint unsigned p);
        longint unsigned r0;
        longint unsigned r1;
        longint unsigned t0;
        longint unsigned t1;
        longint unsigned q;
        longint unsigned tmp;
        r0 = p;
        r1 = v % p;
        t0 = 0;
        t1 = 1;
        while (r1 != 0)
        begin
            q   = r0 / r1;
            tmp = r0 - q * r1;
            r0  = r1;
            r1  = tmp;
            tmp = fsub(t0, fmul(q, t1, p), p);
            t0  = t1;
            t1  = tmp;
        end
        return t0 % p;
    endfunction

    function automatic affine_pt_t chord_end(longint unsigned s, longint unsigned x1,
                                             longint unsigned y1, longint unsigned x2,
                                             longint unsigned p);
        affine_pt_t r;
        r.x   = fsub(fsub(fmul(s, s, p), x1, p), x2, p);
        r.y   = fsub(fmul(s, fsub(x1, r.x, p), p), y1, p);
        r.inf = 1'b0;
        return r;
    endfunction

    function automatic affine_pt_t pt_dbl(affine_pt_t a, longint unsigned p);
        affine_pt_t      r;
        longint unsigned num;
        longint unsigned s;
        r = '{0, 0, 1'b1};
        // vertical tangent gives infinity
        if (a.inf || a.y == 0)
            return r;
        num = (fmul(3, fmul(a.x, a.x, p), p) + longint'(curve_a_q) % p) % p;
        s   = fmul(num, finv(fmul(2, a.y, p), p), p);
        return chord_end(s, a.x, a.y, a.x, p);
    endfunction

    function automatic affine_pt_t pt_sum(affine_pt_t a, affine_pt_t b, longint unsigned p);
        affine_pt_t      r;
        longint unsigned s;
        r = '{0, 0, 1'b1};
        if (a.inf)
            return b;
        if (b.inf)
            return a;
        if (a.x == b.x)
        begin
            if (a.y == b.y)
                return pt_dbl(a, p);
            return r;
        end
        s = fmul(fsub(a.y, b.y, p), finv(fsub(a.x, b.x, p), p), p);
        return chord_end(s, a.x, a.y, b.x, p);
    endfunction

    function automatic affine_pt_t scalar_multiple(logic [ecsm_pkg::FIELD_BITS-1:0] px,
                                                   logic [ecsm_pkg::FIELD_BITS-1:0] py,
                                                   logic [ecsm_pkg::SCALAR_BITS-1:0] k);
        longint unsigned p;
        affine_pt_t      base;
        affine_pt_t      acc;
        p    = (modulus_q < ecsm_pkg::MIN_MODULUS) ? longint'(ecsm_pkg::MIN_MODULUS)
                                                   : longint'(modulus_q);
        base = '{longint'(px) % p, longint'(py) % p, 1'b0};
        acc  = '{0, 0, 1'b1};
        for (int i = 0; i < ecsm_pkg::SCALAR_BITS; i++)
        begin
            if (k[i])
                acc = pt_sum(acc, base, p);
            base = pt_dbl(base, p);
        end
        if (acc.inf)
        begin
            acc.x = 0;
            acc.y = 0;
        end
        return acc;
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // result side: random stalls, optional long hold-off
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen    <= hold_req;
            rx_hold_cnt  <= RX_HOLD;
            out_ch.ready <= 1'b0;
        end
        else if (rx_hold_cnt > 0)
        begin
            rx_hold_cnt <= rx_hold_cnt - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 15);
    end

    // compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        affine_pt_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_pts.size() == 0)
                report_mismatch("result beat with nothing expected");
            else
            begin
                e = expected_pts.pop_front();
                if (out_ch.at_infinity !== e.inf)
                    report_mismatch($sformatf("at_infinity %b, want %b",
                                              out_ch.at_infinity, e.inf));
                if (out_ch.result_x !== ecsm_pkg::FIELD_BITS'(e.x))
                    report_mismatch($sformatf("result_x %0d, want %0d",
                                              out_ch.result_x, e.x));
                if (out_ch.result_y !== ecsm_pkg::FIELD_BITS'(e.y))
                    report_mismatch($sformatf("result_y %0d, want %0d",
                                              out_ch.result_y, e.y));
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // send one base point beat; valid stays high after the beat until the next action
    task automatic send_point(logic [ecsm_pkg::FIELD_BITS-1:0] px,
                              logic [ecsm_pkg::FIELD_BITS-1:0] py,
                              logic [ecsm_pkg::SCALAR_BITS-1:0] k);
        int gap;
        gap = calm ? 0 : (($urandom_range(0, 99) < 15) ? $urandom_range(1, 6) : 0);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.point_x <= px;
        in_ch.point_y <= py;
        in_ch.scalar  <= k;
        do
            @(posedge clk);
        while (!in_ch.ready);
        expected_pts.insert(expected_pts.size(), scalar_multiple(px, py, k));
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_pts.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [ecsm_pkg::CFG_IDX_W-1:0] idx,
                             logic [ecsm_pkg::FIELD_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        if (idx == ecsm_pkg::REG_MODULUS)
            modulus_q = val;
        else
            curve_a_q = val;
    endtask

    task automatic set_curve(logic [ecsm_pkg::FIELD_BITS-1:0] p,
                             logic [ecsm_pkg::FIELD_BITS-1:0] a);
        drain();
        write_reg(ecsm_pkg::REG_MODULUS, p);
        write_reg(ecsm_pkg::REG_CURVE_A, a);
    endtask

    function automatic logic [ecsm_pkg::FIELD_BITS-1:0] rand_field();
        return ecsm_pkg::FIELD_BITS'($urandom());
    endfunction

    // reset defaults: zero scalar, single bits, extremes, vertical tangent
    task automatic test_reset_defaults();
        send_point(3, 6, 0);
        send_point(3, 6, 1);
        send_point(3, 6, 2);
        send_point(3, 6, 5);
        send_point(10, 0, 1);
        send_point(10, 0, 3);
        send_point('1, '1, '1);
        send_point(0, 0, 32'h8000_0000);
        send_point(96, 1, 32'h0000_ffff);
    endtask

    // tiny and degenerate moduli, including values below three
    task automatic test_small_moduli();
        set_curve(3, 0);
        send_point(1, 1, 7);
        send_point(2, 2, 3);
        set_curve(0, 1);
        send_point(1, 2, 6);
        set_curve(1, 2);
        send_point(2, 1, 9);
        set_curve(2, 0);
        send_point(0, 1, 4);
    endtask

    // composite and even moduli, coefficient above the modulus
    task automatic test_composite_moduli();
        set_curve(15, 2147483646);
        send_point(4, 7, 13);
        send_point(5, 10, 32'hffff_ffff);
        set_curve(100, 99);
        send_point(50, 25, 21);
        send_point(12, 0, 6);
    endtask

    // largest field, largest coefficient
    task automatic test_large_field();
        set_curve(2147483647, 2147483646);
        send_point(rand_field(), rand_field(), 32'h0000_0003);
        send_point('1, '1, $urandom());
    endtask

    // long result hold-off while points keep coming, then a full pause
    task automatic test_backpressure();
        set_curve(97, 2);
        hold_req++;
        for (int i = 0; i < 4; i++)
            send_point(rand_field(), rand_field(), $urandom_range(1, 255));
        drain();
    endtask

    // random curves and points, mostly small fields to keep jobs short
    task automatic test_random_points();
        logic [ecsm_pkg::FIELD_BITS-1:0] primes[6] = '{3, 7, 97, 101, 257, 65537};
        logic [ecsm_pkg::FIELD_BITS-1:0] p;
        for (int phase = 0; phase < 10; phase++)
        begin
            calm = (phase < 2);
            if (phase == 9)
                p = 2147483647;
            else
                p = primes[$urandom_range(0, 5)];
            set_curve(p, ($urandom_range(0, 3) == 0) ? rand_field()
                         : ecsm_pkg::FIELD_BITS'($urandom_range(0, 10)));
            for (int i = 0; i < ((phase == 9) ? 2 : 11); i++)
            begin
                logic [ecsm_pkg::SCALAR_BITS-1:0] k;
                case ($urandom_range(0, 3))
                    0: k = $urandom();
                    1: k = $urandom_range(0, 31);
                    default: k = $urandom_range(0, 65535);
                endcase
                send_point(rand_field(),
                           ($urandom_range(0, 9) == 0) ? ecsm_pkg::FIELD_BITS'(0)
                                                       : rand_field(), k);
            end
        end
        calm = 1'b0;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= ecsm_pkg::REG_MODULUS;
        cfg_data      <= '0;
        in_ch.valid   <= 1'b0;
        in_ch.point_x <= '0;
        in_ch.point_y <= '0;
        in_ch.scalar  <= '0;
        modulus_q     = ecsm_pkg::MODULUS_RST;
        curve_a_q     = ecsm_pkg::CURVE_A_RST;
        calm          = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_small_moduli();
        test_composite_moduli();
        test_large_field();
        test_backpressure();
        test_random_points();
        drain();

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
